### hw/rtl/scm_pkg.sv
package scm_pkg;

    localparam int unsigned FIELD_GROUPS = 16;
    localparam int unsigned STATE_W      = 3;

    localparam logic        CMD_WRITE = 1'b0;
    localparam logic        CMD_CHECK = 1'b1;

    localparam logic [1:0]  KIND_NONE         = 2'd0;
    localparam logic [1:0]  KIND_GREEN_GREEN  = 2'd1;
    localparam logic [1:0]  KIND_YELLOW_GREEN = 2'd2;

    localparam logic [2:0]  SG_RED         = 3'd0;
    localparam logic [2:0]  SG_OPEN        = 3'd1;
    localparam logic [2:0]  SG_OPENING     = 3'd2;
    localparam logic [2:0]  SG_GREEN_FLASH = 3'd3;
    localparam logic [2:0]  SG_CLOSING     = 3'd4;

    typedef struct packed {
        logic        command;
        logic [3:0]  row_index;
        logic [15:0] row_bits;
        logic [47:0] group_states;
    } scm_request_t;

    typedef struct packed {
        logic [1:0] conflict_kind;
        logic [3:0] first_group;
        logic [3:0] second_group;
    } scm_result_t;

endpackage

### hw/rtl/signal_group_conflict_monitor_core.sv
// write beat: stored when taken, no result, busy stays low
// check beat: one matrix row tested per cycle, up to n rows, then one result strobe;
// n = min(active_groups, GROUPS); busy high until the strobe
// next beat after a check is taken at the earliest at the edge ending the strobe
// receiver cannot stall: done is high for one cycle only
// asynchronous active-low reset clears the conflict rows and sets active_groups to 16
module signal_group_conflict_monitor_core
    import scm_pkg::*;
#(
    parameter int GROUPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  scm_request_t request,
    input  logic         cfg_wen,
    input  logic [4:0]   cfg_wdata,
    output logic         done,
    output scm_result_t  result
);

    localparam int IDX_W = $clog2(GROUPS);
    localparam int CNT_W = $clog2(GROUPS + 1);
    localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } seq_state_t;

    seq_state_t  state_reg, state_next;
    logic [15:0] rows_reg [GROUPS];
    logic [4:0]  active_groups_reg;
    logic [CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [CNT_W-1:0] n_eff_reg, n_eff_next;
    logic [15:0] col_mask_reg, col_mask_next;
    logic [47:0] states_reg;
    logic        done_reg, done_next;
    scm_result_t result_reg, result_next;

    logic        accept;
    logic [EXT_W-1:0] cnt_ext;
    logic [15:0] above;
    logic [15:0] cand;
    logic [15:0] cur_row;
    logic        row_active;
    logic [3:0]  hit_col;
    logic [2:0]  si;
    logic [2:0]  sj;
    logic [15:0] act_bits;

    function automatic logic sg_green(input logic [2:0] code);
        return (code == SG_OPEN) || (code == SG_OPENING) || (code == SG_GREEN_FLASH);
    endfunction

    function automatic logic sg_lit(input logic [2:0] code);
        return sg_green(code) || (code == SG_CLOSING);
    endfunction

    function automatic logic [3:0] lowest_set(input logic [15:0] v);
        logic [3:0] r;
        r = 4'd0;
        for (int k = 15; k >= 0; k--)
        begin
            if (v[k])
            begin
                r = 4'(k);
            end
        end
        return r;
    endfunction

    assign accept  = start && !busy;
    assign busy    = (state_reg == ST_SCAN);
    assign done    = done_reg;
    assign result  = result_reg;
    assign cnt_ext = EXT_W'(row_cnt_reg);

    // effective count and active-state mask for a new check beat
    always_comb
    begin
        if (int'(active_groups_reg) > GROUPS)
        begin
            n_eff_next = CNT_W'(GROUPS);
        end
        else
        begin
            n_eff_next = CNT_W'(active_groups_reg);
        end
        for (int k = 0; k < 16; k++)
        begin
            act_bits[k] = sg_lit(request.group_states[STATE_W*k +: STATE_W])
                          && (k < int'(n_eff_next));
        end
    end

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            above[k] = (k > int'(cnt_ext));
        end
        cur_row    = rows_reg[IDX_W'(row_cnt_reg)];
        row_active = (int'(cnt_ext) < int'(FIELD_GROUPS)) && col_mask_reg[cnt_ext[3:0]];
        cand       = cur_row & col_mask_reg & above;
        hit_col    = lowest_set(cand);
        si         = states_reg[STATE_W*cnt_ext[3:0] +: STATE_W];
        sj         = states_reg[STATE_W*hit_col +: STATE_W];
    end

    always_comb
    begin
        state_next    = state_reg;
        row_cnt_next  = row_cnt_reg;
        col_mask_next = col_mask_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (request.command == CMD_CHECK))
                begin
                    state_next    = ST_SCAN;
                    row_cnt_next  = '0;
                    col_mask_next = act_bits;
                end
            end
            ST_SCAN:
            begin
                if (row_cnt_reg >= n_eff_reg)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next = '{conflict_kind: KIND_NONE, first_group: 4'd0,
                                    second_group: 4'd0};
                end
                else if (row_active && (cand != 16'd0))
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next.conflict_kind = (sg_green(si) && sg_green(sj))
                                                ? KIND_GREEN_GREEN : KIND_YELLOW_GREEN;
                    result_next.first_group   = cnt_ext[3:0];
                    result_next.second_group  = hit_col;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            done_reg          <= 1'b0;
            active_groups_reg <= 5'd16;
            row_cnt_reg       <= '0;
            for (int k = 0; k < GROUPS; k++)
            begin
                rows_reg[k] <= 16'd0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            row_cnt_reg <= row_cnt_next;
            if (cfg_wen)
            begin
                active_groups_reg <= cfg_wdata;
            end
            // rows outside the store are dropped
            if (accept && (request.command == CMD_WRITE) && (int'(request.row_index) < GROUPS))
            begin
                rows_reg[IDX_W'(request.row_index)] <= request.row_bits;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_mask_reg <= col_mask_next;
        result_reg   <= result_next;
        if (accept && (request.command == CMD_CHECK))
        begin
            n_eff_reg  <= n_eff_next;
            states_reg <= request.group_states;
        end
    end

endmodule

### sim/scm_monitor_checker.sv
`timescale 1ns / 100ps

module scm_monitor_checker
    import scm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         busy,
    input  scm_request_t request,
    input  logic         cfg_wen,
    input  logic [4:0]   cfg_wdata,
    input  logic         done,
    input  scm_result_t  result,
    output int           fail_count,
    output int           pending_count,
    output int           report_count,
    output int           green_green_count,
    output int           yellow_green_count
);

    logic [15:0] matrix_rows [FIELD_GROUPS];
    logic [4:0]  group_count;
    scm_result_t reports_due [$];

    function automatic logic code_green(input logic [2:0] code);
        return code >= SG_OPEN && code <= SG_GREEN_FLASH;
    endfunction

    function automatic logic code_active(input logic [2:0] code);
        return code >= SG_OPEN && code <= SG_CLOSING;
    endfunction

    // row-major scan, first marked pair of active groups wins
    function automatic scm_result_t first_conflict(input logic [47:0] states);
        scm_result_t report;
        int unsigned n;
        logic [2:0]  si;
        logic [2:0]  sj;
        report = '0;
        n = (group_count > FIELD_GROUPS) ? FIELD_GROUPS : group_count;
        for (int i = 0; i < n; i++)
        begin
            si = states[STATE_W*i +: STATE_W];
            if (!code_active(si))
                continue;
            for (int j = i + 1; j < n; j++)
            begin
                sj = states[STATE_W*j +: STATE_W];
                if (matrix_rows[i][j] && code_active(sj))
                begin
                    report.conflict_kind = (code_green(si) && code_green(sj)) ?
                                           KIND_GREEN_GREEN : KIND_YELLOW_GREEN;
                    report.first_group   = 4'(i);
                    report.second_group  = 4'(j);
                    return report;
                end
            end
        end
        return report;
    endfunction

    task automatic compare_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        scm_result_t due;
        if (!rst_n)
        begin
            for (int k = 0; k < FIELD_GROUPS; k++)
                matrix_rows[k] = '0;
            group_count = 5'd16;
            reports_due.delete();
            fail_count = 0;
            pending_count = 0;
            report_count = 0;
            green_green_count = 0;
            yellow_green_count = 0;
        end
        else
        begin
            if (cfg_wen)
                group_count = cfg_wdata;
            if (done)
            begin
                report_count++;
                if (result.conflict_kind == KIND_GREEN_GREEN)
                    green_green_count++;
                if (result.conflict_kind == KIND_YELLOW_GREEN)
                    yellow_green_count++;
                if (reports_due.size() == 0)
                begin
                    $error("result beat with no check outstanding");
                    fail_count++;
                end
                else
                begin
                    due = reports_due.pop_front();
                    compare_field("conflict_kind", due.conflict_kind, result.conflict_kind);
                    compare_field("first_group", due.first_group, result.first_group);
                    compare_field("second_group", due.second_group, result.second_group);
                end
            end
            if (start && !busy)
            begin
                if (request.command == CMD_WRITE)
                    matrix_rows[request.row_index] = request.row_bits;
                else
                    reports_due.push_back(first_conflict(request.group_states));
            end
            pending_count = reports_due.size();
        end
    end

endmodule

### sim/tb_signal_group_conflict_monitor_core.sv
`timescale 1ns / 100ps

module tb_signal_group_conflict_monitor_core;
    import scm_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 500;
    localparam int SEGMENT_ITEMS = 100;
    localparam int SEGMENTS      = 15;

    // state codes the package leaves unnamed, all inactive
    localparam logic [2:0] SG_SPARE_5 = 3'd5;
    localparam logic [2:0] SG_SPARE_6 = 3'd6;
    localparam logic [2:0] SG_SPARE_7 = 3'd7;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    scm_request_t request;
    logic         cfg_wen;
    logic [4:0]   cfg_wdata;
    logic         done;
    scm_result_t  result;

    int fail_count;
    int pending_count;
    int report_count;
    int green_green_count;
    int yellow_green_count;
    int write_beats;
    int check_beats;
    int stall_cycles;
    int sender_idle_pct;

    logic [4:0] count_plan [SEGMENTS] = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd7, 5'd16,
                                          5'd12, 5'd5, 5'd17, 5'd3, 5'd16, 5'd15,
                                          5'd30, 5'd9};

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    signal_group_conflict_monitor_core #(
        .GROUPS (16)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    scm_monitor_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .request            (request),
        .cfg_wen            (cfg_wen),
        .cfg_wdata          (cfg_wdata),
        .done               (done),
        .result             (result),
        .fail_count         (fail_count),
        .pending_count      (pending_count),
        .report_count       (report_count),
        .green_green_count  (green_green_count),
        .yellow_green_count (yellow_green_count)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_wen)
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic logic [47:0] all_codes(input logic [2:0] code);
        return {16{code}};
    endfunction

    function automatic logic [47:0] with_code(input logic [47:0] states, input int k,
                                              input logic [2:0] code);
        states[STATE_W*k +: STATE_W] = code;
        return states;
    endfunction

    function automatic scm_request_t random_request();
        scm_request_t beat;
        int           density;
        beat.command      = ($urandom_range(99) < 35) ? CMD_WRITE : CMD_CHECK;
        beat.row_index    = 4'($urandom);
        beat.row_bits     = 16'($urandom);
        beat.group_states = {16'($urandom), 32'($urandom)};
        if (beat.command == CMD_WRITE)
        begin
            // sparse rows push the first hit deep into the scan
            case ($urandom_range(9)) inside
                [0:2]:   beat.row_bits = 16'd1 << $urandom_range(15);
                3:       beat.row_bits = (16'd1 << $urandom_range(15)) |
                                         (16'd1 << $urandom_range(15));
                4:       beat.row_bits = '0;
                5:       beat.row_bits = '1;
                default: ;
            endcase
        end
        else if ($urandom_range(3) != 0)
        begin
            density = $urandom_range(1, 8);
            for (int k = 0; k < FIELD_GROUPS; k++)
            begin
                if ($urandom_range(15) < density)
                    beat.group_states[STATE_W*k +: STATE_W] = 3'($urandom_range(SG_OPEN,
                                                                              SG_CLOSING));
                else if ($urandom_range(1) == 0)
                    beat.group_states[STATE_W*k +: STATE_W] = SG_RED;
                else
                    beat.group_states[STATE_W*k +: STATE_W] = 3'($urandom_range(SG_SPARE_5,
                                                                              SG_SPARE_7));
            end
        end
        return beat;
    endfunction

    // entered and left at a falling edge
    task automatic drive_beat(input scm_request_t beat);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start   <= 1'b1;
        request <= beat;
        do
            @(posedge clk);
        while (busy);
        if (beat.command == CMD_WRITE)
            write_beats++;
        else
            check_beats++;
        @(negedge clk);
    endtask

    task automatic send_write(input logic [3:0] row, input logic [15:0] bits);
        scm_request_t beat;
        beat           = random_request();
        beat.command   = CMD_WRITE;
        beat.row_index = row;
        beat.row_bits  = bits;
        drive_beat(beat);
    endtask

    task automatic send_check(input logic [47:0] states);
        scm_request_t beat;
        beat              = random_request();
        beat.command      = CMD_CHECK;
        beat.group_states = states;
        drive_beat(beat);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_group_count(input logic [4:0] value);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        request         = '0;
        cfg_wen         = 1'b0;
        cfg_wdata       = '0;
        write_beats     = 0;
        check_beats     = 0;
        stall_cycles    = 0;
        sender_idle_pct = 33;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // reset matrix and group count of sixteen
        send_check(all_codes(SG_OPEN));
        send_write(4'd15, 16'hFFFF);
        send_check(all_codes(SG_OPEN));
        send_write(4'd0, 16'h8000);
        send_check(all_codes(SG_OPEN));
        send_check(all_codes(SG_CLOSING));
        send_check(with_code(with_code(all_codes(SG_SPARE_5), 0, SG_OPEN), 15, SG_RED));
        send_write(4'd14, 16'h8000);
        send_check(with_code(with_code(all_codes(SG_SPARE_6), 14, SG_GREEN_FLASH),
                             15, SG_CLOSING));
        send_write(4'd3, 16'h0030);
        send_check(with_code(with_code(all_codes(SG_OPEN), 3, SG_OPENING), 4, SG_SPARE_7));
        send_check(with_code(with_code(with_code(all_codes(SG_OPEN), 3, SG_OPENING),
                                       4, SG_SPARE_7), 0, SG_RED));
        send_check('1);
        send_check('0);
        send_write(4'd0, 16'h0001);
        send_check(all_codes(SG_OPEN));
        send_write(4'd3, 16'h0000);
        send_write(4'd14, 16'h0000);
        send_write(4'd7, 16'hFF00);

        // group count above range, at the boundary of row 7 and at the low end
        set_group_count(5'd31);
        send_check(all_codes(SG_OPEN));
        set_group_count(5'd8);
        send_check(all_codes(SG_OPEN));
        set_group_count(5'd9);
        send_check(all_codes(SG_OPEN));
        send_write(4'd1, 16'h0004);
        set_group_count(5'd0);
        send_check(all_codes(SG_OPEN));
        set_group_count(5'd1);
        send_check(all_codes(SG_OPEN));
        set_group_count(5'd2);
        send_check(all_codes(SG_OPEN));
        set_group_count(5'd3);
        send_check(all_codes(SG_OPEN));

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            set_group_count(count_plan[seg]);
            sender_idle_pct = (seg < SEGMENTS / 3) ? 33 : (seg < 2 * SEGMENTS / 3) ? 70 : 0;
            repeat (SEGMENT_ITEMS) drive_beat(random_request());
        end

        wait_idle();
        $display("%0d request beats: %0d matrix row writes, %0d checks over %0d group counts",
                 write_beats + check_beats, write_beats, check_beats, SEGMENTS + 8);
        $display("%0d result beats: %0d green-green, %0d yellow-green, rest clear",
                 report_count, green_green_count, yellow_green_count);
        if (fail_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
